[hw/rtl/hre_pkg.sv]
// ----------------------------------------------------------------------------
// hre_pkg
// Shared types and constants for the hash run-length encoder.
// ----------------------------------------------------------------------------
package hre_pkg;

    localparam int HASH_W   = 64;
    localparam int FLAGS_W  = 64;
    localparam int LEN_W    = 16;
    localparam int VNUM_W   = 32;

    localparam logic [LEN_W-1:0]  CHUNK_MAX = 16'hFFFF;
    localparam logic [VNUM_W-1:0] VNUM_MAX  = 32'hFFFF_FFFF;

    // One emitted vertex
    typedef struct packed {
        logic [HASH_W-1:0]  hash_high;
        logic [HASH_W-1:0]  hash_low;
        logic [FLAGS_W-1:0] flags;
        logic [LEN_W-1:0]   start_ordinal;
        logic [LEN_W-1:0]   run_count;
        logic [VNUM_W-1:0]  vertex_number;
        logic               final_vertex;
    } vertex_t;

    // Vertices produced by one item, in emit order (first, then second)
    typedef struct packed {
        vertex_t    first;
        vertex_t    second;
        logic [1:0] count;
    } emit_t;

    // Output buffer status back to the top level
    typedef struct packed {
        logic can_take;     // room for up to two vertices this cycle
        logic spare_busy;   // second vertex waiting behind the output register
    } obuf_stat_t;

endpackage

[hw/rtl/hre_core.sv]
// ----------------------------------------------------------------------------
// hre_core
// Run tracking state and vertex generation for one element per cycle while fire is high.
// ----------------------------------------------------------------------------
module hre_core #(
    parameter int COUNT_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          fire,
    input  logic [hre_pkg::HASH_W-1:0]    hash_high,
    input  logic [hre_pkg::HASH_W-1:0]    hash_low,
    input  logic [hre_pkg::FLAGS_W-1:0]   item_flags,
    input  logic                          last_item,
    output hre_pkg::emit_t                emit
);

    localparam logic [COUNT_BITS-1:0] POS_MAX = {COUNT_BITS{1'b1}};

    logic [hre_pkg::HASH_W-1:0]  held_hash_high_reg, held_hash_high_next;
    logic [hre_pkg::HASH_W-1:0]  held_hash_low_reg,  held_hash_low_next;
    logic [hre_pkg::FLAGS_W-1:0] held_flags_reg,     held_flags_next;
    logic [hre_pkg::LEN_W-1:0]   held_length_reg,    held_length_next;
    logic [COUNT_BITS-1:0]       chunk_start_reg,    chunk_start_next;
    logic [COUNT_BITS-1:0]       position_reg,       position_next;
    logic [hre_pkg::VNUM_W-1:0]  vcount_reg,         vcount_next;

    logic                        same_key;
    logic                        extend;
    logic                        emit_mid;
    logic [COUNT_BITS-1:0]       pos_inc;
    logic [hre_pkg::VNUM_W-1:0]  vnum_one;
    logic [hre_pkg::VNUM_W-1:0]  vnum_two;
    logic [hre_pkg::LEN_W-1:0]   new_length;
    logic [COUNT_BITS-1:0]       new_start;
    hre_pkg::vertex_t            mid_vtx;
    hre_pkg::vertex_t            fin_vtx;

    // Ordinal is written as zero above 16 bits
    function automatic logic [hre_pkg::LEN_W-1:0] ordinal(input logic [COUNT_BITS-1:0] pos);
        logic [hre_pkg::LEN_W-1:0] res;
        res = (pos[COUNT_BITS-1:hre_pkg::LEN_W] == '0) ? pos[hre_pkg::LEN_W-1:0] : '0;
        return res;
    endfunction

    always_comb begin
        pos_inc  = (position_reg != POS_MAX) ? position_reg + 1'b1 : position_reg;
        same_key = (held_length_reg != '0) && (hash_high == held_hash_high_reg) &&
                   (hash_low == held_hash_low_reg) && (item_flags == held_flags_reg);
        extend   = same_key && (held_length_reg != hre_pkg::CHUNK_MAX);
        emit_mid = !extend && (held_length_reg != '0);

        vnum_one = (vcount_reg != hre_pkg::VNUM_MAX) ? vcount_reg + 1'b1 : vcount_reg;
        vnum_two = (vnum_one != hre_pkg::VNUM_MAX) ? vnum_one + 1'b1 : vnum_one;

        new_length = extend ? held_length_reg + 1'b1 : hre_pkg::LEN_W'(1);
        new_start  = extend ? chunk_start_reg : pos_inc;

        mid_vtx.hash_high     = held_hash_high_reg;
        mid_vtx.hash_low      = held_hash_low_reg;
        mid_vtx.flags         = held_flags_reg;
        mid_vtx.start_ordinal = ordinal(chunk_start_reg);
        mid_vtx.run_count     = held_length_reg;
        mid_vtx.vertex_number = vnum_one;
        mid_vtx.final_vertex  = 1'b0;

        // The open chunk always matches the incoming key after this element
        fin_vtx.hash_high     = hash_high;
        fin_vtx.hash_low      = hash_low;
        fin_vtx.flags         = item_flags;
        fin_vtx.start_ordinal = ordinal(new_start);
        fin_vtx.run_count     = new_length;
        fin_vtx.vertex_number = emit_mid ? vnum_two : vnum_one;
        fin_vtx.final_vertex  = 1'b1;

        emit.first  = emit_mid ? mid_vtx : fin_vtx;
        emit.second = fin_vtx;
        emit.count  = {1'b0, emit_mid} + {1'b0, last_item};
    end

    always_comb begin
        held_hash_high_next = held_hash_high_reg;
        held_hash_low_next  = held_hash_low_reg;
        held_flags_next     = held_flags_reg;
        held_length_next    = held_length_reg;
        chunk_start_next    = chunk_start_reg;
        position_next       = position_reg;
        vcount_next         = vcount_reg;
        if (fire) begin
            if (last_item) begin
                held_hash_high_next = '0;
                held_hash_low_next  = '0;
                held_flags_next     = '0;
                held_length_next    = '0;
                chunk_start_next    = '0;
                position_next       = '0;
                vcount_next         = '0;
            end else begin
                held_hash_high_next = hash_high;
                held_hash_low_next  = hash_low;
                held_flags_next     = item_flags;
                held_length_next    = new_length;
                chunk_start_next    = new_start;
                position_next       = pos_inc;
                vcount_next         = emit_mid ? vnum_one : vcount_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_hash_high_reg <= '0;
            held_hash_low_reg  <= '0;
            held_flags_reg     <= '0;
            held_length_reg    <= '0;
            chunk_start_reg    <= '0;
            position_reg       <= '0;
            vcount_reg         <= '0;
        end else begin
            held_hash_high_reg <= held_hash_high_next;
            held_hash_low_reg  <= held_hash_low_next;
            held_flags_reg     <= held_flags_next;
            held_length_reg    <= held_length_next;
            chunk_start_reg    <= chunk_start_next;
            position_reg       <= position_next;
            vcount_reg         <= vcount_next;
        end
    end

endmodule

[hw/rtl/hre_obuf.sv]
// ----------------------------------------------------------------------------
// hre_obuf
// Output register plus one spare register for the second vertex of an item.
// ----------------------------------------------------------------------------
module hre_obuf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  hre_pkg::emit_t       emit,
    input  logic                 m_ready,
    output logic                 m_valid,
    output hre_pkg::vertex_t     m_vertex,
    output hre_pkg::obuf_stat_t  stat
);

    hre_pkg::vertex_t out_reg,   out_next;
    hre_pkg::vertex_t spare_reg, spare_next;
    logic             out_valid_reg,   out_valid_next;
    logic             spare_valid_reg, spare_valid_next;
    logic             out_free;

    always_comb begin
        out_free         = !out_valid_reg || m_ready;
        out_next         = out_reg;
        spare_next       = spare_reg;
        out_valid_next   = out_valid_reg;
        spare_valid_next = spare_valid_reg;
        if (spare_valid_reg) begin
            if (out_free) begin
                out_next         = spare_reg;
                out_valid_next   = 1'b1;
                spare_valid_next = 1'b0;
            end
        end else if (push && emit.count != 2'd0) begin
            out_next       = emit.first;
            out_valid_next = 1'b1;
            if (emit.count == 2'd2) begin
                spare_next       = emit.second;
                spare_valid_next = 1'b1;
            end
        end else if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else begin
            out_valid_reg   <= out_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg   <= out_next;
        spare_reg <= spare_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_vertex        = out_reg;
    assign stat.can_take   = !spare_valid_reg && out_free;
    assign stat.spare_busy = spare_valid_reg;

endmodule

[hw/rtl/hash_run_length_encoder.sv]
// ----------------------------------------------------------------------------
// hash_run_length_encoder
// Collapses runs of equal (hash, flags) elements into vertices.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one element per item (128-bit hash in two halves, 64-bit
//   flag word, last mark). m_* channel: vertices with hash, flags,
//   one-based start ordinal (0 above 65535), run count, vertex number and
//   final mark.
//   An item passes an input register, then the run logic, then the output
//   register, which drives m_*. Throughput is one item per cycle while the
//   output side can take both vertices. Most items give zero or one vertex;
//   a run that reaches 65535 elements is cut into a new vertex. A last item
//   that also closes the open chunk (key change or full 65535-element chunk)
//   gives two vertices; the second waits in a spare register and holds off
//   the next item until it moves into the output register.
//   Reset (aresetn low, synchronous) clears all valid flags and run state and
//   starts a new sequence; a last item clears the run state once processed.
//   When m_ready is low the output register holds its vertex, the run logic
//   stalls and s_ready falls once the input register is full.
// ----------------------------------------------------------------------------
module hash_run_length_encoder #(
    parameter int COUNT_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_hash_high,
    input  logic [63:0] s_hash_low,
    input  logic [63:0] s_item_flags,
    input  logic        s_last_item,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_vertex_hash_high,
    output logic [63:0] m_vertex_hash_low,
    output logic [63:0] m_vertex_flags,
    output logic [15:0] m_start_ordinal,
    output logic [15:0] m_run_count,
    output logic [31:0] m_vertex_number,
    output logic        m_final_vertex
);

    // Input register
    logic        in_valid_reg;
    logic [63:0] in_hash_high_reg;
    logic [63:0] in_hash_low_reg;
    logic [63:0] in_flags_reg;
    logic        in_last_reg;

    logic                 proc_fire;
    hre_pkg::emit_t       emit;
    hre_pkg::obuf_stat_t  obuf_stat;
    hre_pkg::vertex_t     m_vertex;

    // Element is processed once the output side has room for both vertices
    assign proc_fire = in_valid_reg && obuf_stat.can_take;
    assign s_ready   = !in_valid_reg || proc_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_hash_high_reg <= s_hash_high;
            in_hash_low_reg  <= s_hash_low;
            in_flags_reg     <= s_item_flags;
            in_last_reg      <= s_last_item;
        end
    end

    hre_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (proc_fire),
        .hash_high  (in_hash_high_reg),
        .hash_low   (in_hash_low_reg),
        .item_flags (in_flags_reg),
        .last_item  (in_last_reg),
        .emit       (emit)
    );

    hre_obuf u_obuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (proc_fire),
        .emit     (emit),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .m_vertex (m_vertex),
        .stat     (obuf_stat)
    );

    assign m_vertex_hash_high = m_vertex.hash_high;
    assign m_vertex_hash_low  = m_vertex.hash_low;
    assign m_vertex_flags     = m_vertex.flags;
    assign m_start_ordinal    = m_vertex.start_ordinal;
    assign m_run_count        = m_vertex.run_count;
    assign m_vertex_number    = m_vertex.vertex_number;
    assign m_final_vertex     = m_vertex.final_vertex;

    // A waiting second vertex always sits behind a full output register
    a_spare_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        obuf_stat.spare_busy |-> m_valid)
        else $error("spare vertex without output vertex");

    // Every vertex covers at least one element and has a nonzero number
    a_vertex_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_run_count != 16'd0 && m_vertex_number != 32'd0))
        else $error("empty vertex emitted");

    // A spare vertex is always the final one of its sequence
    a_spare_is_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (obuf_stat.spare_busy && m_ready) |=> (m_valid && m_final_vertex))
        else $error("spare vertex not final");

endmodule
